[design/urkf_pkg.sv]
// ============================================================================
// urkf_pkg
// Shared widths, codes, reset values and types of the ultrasonic range filter.
// ============================================================================
package urkf_pkg;

    localparam int PW_W       = 16;
    localparam int DIST_W     = 25;
    localparam int STATUS_W   = 2;
    localparam int COV_W      = 32;
    localparam int CM_W       = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_W     = 16;
    localparam int GAIN_W     = FRAC_W + 1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ERROR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CM            = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CM            = 3'd6;

    // Configuration reset values.
    localparam logic [COV_W-1:0]  RST_PROCESS_NOISE     = 32'd6554;
    localparam logic [COV_W-1:0]  RST_MEASUREMENT_NOISE = 32'd6554;
    localparam logic [COV_W-1:0]  RST_INITIAL_ERROR     = 32'd65536;
    localparam logic [DIST_W-1:0] RST_INITIAL_ESTIMATE  = 25'd0;
    localparam logic [PW_W-1:0]   RST_TIMEOUT_US        = 16'd26000;
    localparam logic [CM_W-1:0]   RST_MIN_CM            = 9'd2;
    localparam logic [CM_W-1:0]   RST_MAX_CM            = 9'd400;

    // Sound travels one centimetre out and back in 58 us.
    localparam int US_PER_CM   = 58;
    localparam int HALF_US     = US_PER_CM / 2;
    // pw * 2^16 / 58 equals pw * 2^15 / 29; the reciprocal of 29 is scaled by 2^36.
    localparam int RECIP_SHIFT = 21;
    localparam logic [31:0] RECIP_HALF_US = 32'((64'd1 << 36) / 64'(HALF_US));
    localparam int QUO_W       = PW_W + 32 - RECIP_SHIFT;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [DIST_W-1:0]   meas;
        logic [STATUS_W-1:0] status;
    } urkf_item_t;

    typedef struct packed {
        logic [PW_W-1:0] timeout_us;
        logic [CM_W-1:0] min_cm;
        logic [CM_W-1:0] max_cm;
    } urkf_gate_cfg_t;

    typedef struct packed {
        logic [COV_W-1:0]  process_noise;
        logic [COV_W-1:0]  measurement_noise;
        logic [COV_W-1:0]  initial_error;
        logic [DIST_W-1:0] initial_estimate;
    } urkf_filt_cfg_t;

endpackage

[design/urkf_if.sv]
// ============================================================================
// urkf_if
// Channel interfaces of the range filter: echo input, result output, config.
// ============================================================================
interface urkf_echo_if;
    logic                        valid;
    logic                        ready;
    logic [urkf_pkg::PW_W-1:0]   pulse_width;

    modport source (output valid, output pulse_width, input ready);
    modport sink   (input valid, input pulse_width, output ready);
endinterface

interface urkf_result_if;
    logic                          valid;
    logic                          ready;
    logic [urkf_pkg::DIST_W-1:0]   distance;
    logic [urkf_pkg::STATUS_W-1:0] status;

    modport source (output valid, output distance, output status, input ready);
    modport sink   (input valid, input distance, input status, output ready);
endinterface

interface urkf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [urkf_pkg::CFG_IDX_W-1:0]  index;
    logic [urkf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/urkf_front.sv]
// ============================================================================
// urkf_front
// Accepts echo widths, classifies them and converts them to centimetres.
// ============================================================================
module urkf_front (
    input  logic                     clk,
    input  logic                     rst_n,
    urkf_echo_if.sink                echo,
    input  urkf_pkg::urkf_gate_cfg_t gate_cfg,
    output logic                     item_valid,
    input  logic                     item_ready,
    output urkf_pkg::urkf_item_t     item
);
    import urkf_pkg::*;

    localparam int NUM_W = PW_W + FRAC_W - 1;

    logic                s1_valid_reg;
    logic [PW_W-1:0]     s1_pw_reg;
    logic [STATUS_W-1:0] s1_status_reg;
    logic                s2_valid_reg;
    logic [PW_W-1:0]     s2_pw_reg;
    logic [STATUS_W-1:0] s2_status_reg;
    logic [QUO_W-1:0]    s2_quo_reg;

    logic                s1_free;
    logic                s2_free;
    logic [PW_W-1:0]     min_us;
    logic [PW_W-1:0]     max_us;
    logic [STATUS_W-1:0] in_status;
    logic [PW_W+31:0]    recip_prod;
    logic [NUM_W-1:0]    num;
    logic [NUM_W-1:0]    quo_x;
    logic [NUM_W-1:0]    rem;
    logic [QUO_W-1:0]    meas_full;

    assign s2_free    = !s2_valid_reg || item_ready;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign echo.ready = s1_free;

    // Bounds in microseconds keep the range test exact.
    assign min_us = PW_W'(gate_cfg.min_cm) * PW_W'(US_PER_CM);
    assign max_us = PW_W'(gate_cfg.max_cm) * PW_W'(US_PER_CM);

    always_comb
    begin
        if (echo.pulse_width == '0 || echo.pulse_width > gate_cfg.timeout_us)
        begin
            in_status = STATUS_TIMEOUT;
        end
        else if (echo.pulse_width < min_us || echo.pulse_width > max_us)
        begin
            in_status = STATUS_RANGE;
        end
        else
        begin
            in_status = STATUS_OK;
        end
    end

    // The reciprocal estimate is the true quotient or one below it.
    assign recip_prod = {32'b0, s1_pw_reg} * {{PW_W{1'b0}}, RECIP_HALF_US};

    assign num       = {s2_pw_reg, {(FRAC_W-1){1'b0}}};
    assign quo_x     = NUM_W'(s2_quo_reg) * NUM_W'(HALF_US);
    assign rem       = num - quo_x;
    assign meas_full = s2_quo_reg + QUO_W'(rem >= NUM_W'(HALF_US));

    assign item_valid  = s2_valid_reg;
    assign item.meas   = meas_full[DIST_W-1:0];
    assign item.status = s2_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= echo.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && echo.valid)
        begin
            s1_pw_reg     <= echo.pulse_width;
            s1_status_reg <= in_status;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_pw_reg     <= s1_pw_reg;
            s2_status_reg <= s1_status_reg;
            s2_quo_reg    <= recip_prod[RECIP_SHIFT +: QUO_W];
        end
    end

endmodule

[design/urkf_queue.sv]
// ============================================================================
// urkf_queue
// Short queue of classified items between the front and the filter core.
// ============================================================================
module urkf_queue #(
    parameter int DEPTH = urkf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push_valid,
    output logic                            push_ready,
    input  urkf_pkg::urkf_item_t            push_item,
    output logic                            pop_valid,
    input  logic                            pop_ready,
    output urkf_pkg::urkf_item_t            pop_item,
    output logic [$clog2(DEPTH+1)-1:0]      level
);
    import urkf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    urkf_item_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign level      = count_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[design/urkf_back.sv]
// ============================================================================
// urkf_back
// Filter core: runs one scalar Kalman update per accepted measurement.
// ============================================================================
module urkf_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  urkf_pkg::urkf_filt_cfg_t filt_cfg,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  urkf_pkg::urkf_item_t     item,
    urkf_result_if.source            result
);
    import urkf_pkg::*;

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_UPD  = 3'd6;

    localparam int DEN_W  = COV_W + 1;
    localparam int CNT_W  = $clog2(GAIN_W);
    localparam int PX_W   = GAIN_W + DIST_W;
    localparam int PP_W   = GAIN_W + COV_W;
    localparam logic [GAIN_W-1:0] ONE_Q = GAIN_W'(1) << FRAC_W;

    logic [2:0]          state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [DIST_W-1:0]   est_reg, est_next;
    logic [COV_W-1:0]    cov_reg, cov_next;
    logic [DIST_W-1:0]   meas_reg, meas_next;
    logic [COV_W-1:0]    psat_reg, psat_next;
    logic [DEN_W-1:0]    denom_reg, denom_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [GAIN_W-1:0]   quo_reg, quo_next;
    logic                feed_reg, feed_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                up_reg, up_next;
    logic [PX_W-1:0]     prod_x_reg, prod_x_next;
    logic [PP_W-1:0]     prod_p_reg, prod_p_next;

    logic                out_free;
    logic [DEN_W-1:0]    psum;
    logic [DEN_W-1:0]    denom;
    logic [DEN_W:0]      trial;
    logic                take;
    logic [DIST_W-1:0]   diff;
    logic [DIST_W:0]     step;
    logic [DIST_W:0]     est_upd;

    assign out_free        = !out_valid_reg || result.ready;
    assign item_ready      = (state_reg == ST_IDLE) && out_free;
    assign result.valid    = out_valid_reg;
    assign result.distance = out_dist_reg;
    assign result.status   = out_status_reg;

    assign psum  = {1'b0, cov_reg} + {1'b0, filt_cfg.process_noise};
    assign denom = {1'b0, psat_reg} + {1'b0, filt_cfg.measurement_noise};
    assign trial = {rem_reg, feed_reg};
    assign take  = trial >= {1'b0, denom_reg};
    assign diff  = (meas_reg >= est_reg) ? meas_reg - est_reg : est_reg - meas_reg;
    assign step  = prod_x_reg[FRAC_W +: DIST_W+1];
    assign est_upd = up_reg ? {1'b0, est_reg} + step : {1'b0, est_reg} - step;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        out_dist_next   = out_dist_reg;
        out_status_next = out_status_reg;
        est_next        = est_reg;
        cov_next        = cov_reg;
        meas_next       = meas_reg;
        psat_next       = psat_reg;
        denom_next      = denom_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        feed_next       = feed_reg;
        cnt_next        = cnt_reg;
        up_next         = up_reg;
        prod_x_next     = prod_x_reg;
        prod_p_next     = prod_p_reg;

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                est_next   = filt_cfg.initial_estimate;
                cov_next   = filt_cfg.initial_error;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item_valid && item_ready)
                begin
                    if (item.status != STATUS_OK)
                    begin
                        out_valid_next  = 1'b1;
                        out_dist_next   = '0;
                        out_status_next = item.status;
                    end
                    else
                    begin
                        meas_next  = item.meas;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                psat_next  = psum[COV_W] ? '1 : psum[COV_W-1:0];
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                // The gain is below two to the seventeenth, so the first
                // remainder already holds all but the last seventeen bits.
                denom_next = denom;
                rem_next   = {2'b0, psat_reg[COV_W-1:1]};
                feed_next  = psat_reg[0];
                quo_next   = '0;
                cnt_next   = CNT_W'(GAIN_W-1);
                state_next = (denom == '0) ? ST_MUL : ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = take ? DEN_W'(trial - {1'b0, denom_reg}) : trial[DEN_W-1:0];
                quo_next  = {quo_reg[GAIN_W-2:0], take};
                feed_next = 1'b0;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                up_next     = meas_reg >= est_reg;
                prod_x_next = PX_W'(quo_reg) * PX_W'(diff);
                prod_p_next = PP_W'(psat_reg) * PP_W'(ONE_Q - quo_reg);
                state_next  = ST_UPD;
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    est_next        = est_upd[DIST_W-1:0];
                    cov_next        = prod_p_reg[FRAC_W +: COV_W];
                    out_valid_next  = 1'b1;
                    out_dist_next   = est_upd[DIST_W-1:0];
                    out_status_next = STATUS_OK;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dist_reg   <= out_dist_next;
        out_status_reg <= out_status_next;
        est_reg        <= est_next;
        cov_reg        <= cov_next;
        meas_reg       <= meas_next;
        psat_reg       <= psat_next;
        denom_reg      <= denom_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        feed_reg       <= feed_next;
        cnt_reg        <= cnt_next;
        up_reg         <= up_next;
        prod_x_reg     <= prod_x_next;
        prod_p_reg     <= prod_p_next;
    end

endmodule

[design/ultrasonic_range_kalman_filter_top.sv]
// ============================================================================
// ultrasonic_range_kalman_filter_top
// Echo width to filtered distance: gating front, item queue, Kalman core.
// ============================================================================
// Path: an accepted echo goes through front stages s1 and s2, the queue and
// core states IDLE, SUM, PREP, DIV, MUL and UPD; a rejected one ends in IDLE.
// The core takes no new echo until its update is out, bound by the serial gain
// divider (17 steps); rejected echoes pass one per cycle if output is free.
// Reset: registers take their reset values; the filter state is loaded from
// the initial registers in the first cycle after reset.
module ultrasonic_range_kalman_filter_top #(
    parameter int QUEUE_DEPTH = urkf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    urkf_echo_if.sink     echo,
    urkf_result_if.source result,
    urkf_cfg_if.sink      cfg
);
    import urkf_pkg::*;

    localparam int LEVEL_W = $clog2(QUEUE_DEPTH+1);

    logic [COV_W-1:0]  process_noise_reg;
    logic [COV_W-1:0]  measurement_noise_reg;
    logic [COV_W-1:0]  initial_error_reg;
    logic [DIST_W-1:0] initial_estimate_reg;
    logic [PW_W-1:0]   timeout_us_reg;
    logic [CM_W-1:0]   min_cm_reg;
    logic [CM_W-1:0]   max_cm_reg;

    urkf_gate_cfg_t    gate_cfg;
    urkf_filt_cfg_t    filt_cfg;
    logic              f_valid;
    logic              f_ready;
    urkf_item_t        f_item;
    logic              q_valid;
    logic              q_ready;
    urkf_item_t        q_item;
    logic [LEVEL_W-1:0] q_level;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_noise_reg     <= RST_PROCESS_NOISE;
            measurement_noise_reg <= RST_MEASUREMENT_NOISE;
            initial_error_reg     <= RST_INITIAL_ERROR;
            initial_estimate_reg  <= RST_INITIAL_ESTIMATE;
            timeout_us_reg        <= RST_TIMEOUT_US;
            min_cm_reg            <= RST_MIN_CM;
            max_cm_reg            <= RST_MAX_CM;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_PROCESS_NOISE:     process_noise_reg     <= cfg.data;
                REG_MEASUREMENT_NOISE: measurement_noise_reg <= cfg.data;
                REG_INITIAL_ERROR:     initial_error_reg     <= cfg.data;
                REG_INITIAL_ESTIMATE:  initial_estimate_reg  <= cfg.data[DIST_W-1:0];
                REG_TIMEOUT_US:        timeout_us_reg        <= cfg.data[PW_W-1:0];
                REG_MIN_CM:            min_cm_reg            <= cfg.data[CM_W-1:0];
                REG_MAX_CM:            max_cm_reg            <= cfg.data[CM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign gate_cfg.timeout_us         = timeout_us_reg;
    assign gate_cfg.min_cm             = min_cm_reg;
    assign gate_cfg.max_cm             = max_cm_reg;
    assign filt_cfg.process_noise      = process_noise_reg;
    assign filt_cfg.measurement_noise  = measurement_noise_reg;
    assign filt_cfg.initial_error      = initial_error_reg;
    assign filt_cfg.initial_estimate   = initial_estimate_reg;

    urkf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .echo       (echo),
        .gate_cfg   (gate_cfg),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    urkf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item),
        .level      (q_level)
    );

    urkf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .filt_cfg   (filt_cfg),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .result     (result)
    );

    // A rejected echo always reports a zero distance.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != STATUS_OK |-> result.distance == '0)
        else $error("rejected result with nonzero distance");

    // The queue never holds more items than it has entries.
    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= LEVEL_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

    // An item the queue cannot take stays in the front unchanged.
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |=> f_valid && $stable(f_item))
        else $error("front item lost while queue full");

endmodule

[verif/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking bench for the ultrasonic range filter: echo widths are sent
// through the echo channel, and each result is checked against a predictor
// of the echo gate and the fixed-point Kalman step or a directed-table row.
// ============================================================================
module tb_top;

    import urkf_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 30;
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 148;
    localparam int PRINT_LIMIT     = 40;
    localparam int DIRECTED_ROWS   = 39;

    // Index 7 is not a register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [DIST_W-1:0]   distance;
        logic [STATUS_W-1:0] status;
    } range_result_t;

    typedef enum logic [1:0] {ROW_ECHO, ROW_CFG} row_kind_e;
    typedef enum logic [1:0] {SINK_STEADY, SINK_COIN, SINK_BURSTY} sink_mode_e;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [31:0]           value;
        bit                    typed;
        logic [DIST_W-1:0]     distance;
        logic [STATUS_W-1:0]   status;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    urkf_echo_if   echo_ch ();
    urkf_result_if result_ch ();
    urkf_cfg_if    cfg_ch ();

    ultrasonic_range_kalman_filter_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .echo   (echo_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Configuration copy and filter state of the predictor.
    logic [COV_W-1:0]  noise_q        = RST_PROCESS_NOISE;
    logic [COV_W-1:0]  noise_r        = RST_MEASUREMENT_NOISE;
    logic [COV_W-1:0]  init_cov       = RST_INITIAL_ERROR;
    logic [DIST_W-1:0] init_est       = RST_INITIAL_ESTIMATE;
    logic [PW_W-1:0]   timeout_limit  = RST_TIMEOUT_US;
    logic [CM_W-1:0]   min_range_cm   = RST_MIN_CM;
    logic [CM_W-1:0]   max_range_cm   = RST_MAX_CM;
    logic [DIST_W-1:0] est_q16        = RST_INITIAL_ESTIMATE;
    logic [COV_W-1:0]  cov_q16        = RST_INITIAL_ERROR;

    range_result_t pending_ranges [$];
    range_result_t oldest_range;
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;
    int            burst_left     = 0;
    int            sink_hold      = 0;
    bit            steady_sender  = 1'b0;
    bit            block_busy     = 1'b0;
    sink_mode_e    sink_mode      = SINK_BURSTY;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ECHO, '0, 32'd0,        1'b1, 25'd0, STATUS_TIMEOUT},
        '{ROW_ECHO, '0, 32'd65535,    1'b1, 25'd0, STATUS_TIMEOUT},
        '{ROW_ECHO, '0, 32'd26001,    1'b1, 25'd0, STATUS_TIMEOUT},
        '{ROW_ECHO, '0, 32'd26000,    1'b1, 25'd0, STATUS_RANGE},
        '{ROW_ECHO, '0, 32'd115,      1'b1, 25'd0, STATUS_RANGE},
        '{ROW_ECHO, '0, 32'd23201,    1'b1, 25'd0, STATUS_RANGE},
        '{ROW_ECHO, '0, 32'd116,      1'b0, 25'd0, STATUS_OK},
        '{ROW_ECHO, '0, 32'd23200,    1'b0, 25'd0, STATUS_OK},
        '{ROW_ECHO, '0, 32'd5800,     1'b0, 25'd0, STATUS_OK},
        '{ROW_ECHO, '0, 32'd1,        1'b1, 25'd0, STATUS_RANGE},
        '{ROW_CFG,  REG_MIN_CM, 32'd300, 1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_MAX_CM, 32'd100, 1'b0, 25'd0, STATUS_OK},
        '{ROW_ECHO, '0, 32'd11600,    1'b1, 25'd0, STATUS_RANGE},
        '{ROW_ECHO, '0, 32'd17400,    1'b1, 25'd0, STATUS_RANGE},
        '{ROW_ECHO, '0, 32'd30000,    1'b1, 25'd0, STATUS_TIMEOUT},
        '{ROW_CFG,  REG_MIN_CM, 32'd0,   1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_MAX_CM, 32'd400, 1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_PROCESS_NOISE, 32'd0, 1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_MEASUREMENT_NOISE, 32'd0, 1'b0, 25'd0, STATUS_OK},
        '{ROW_ECHO, '0, 32'd1,        1'b0, 25'd0, STATUS_OK},
        '{ROW_ECHO, '0, 32'd11600,    1'b0, 25'd0, STATUS_OK},
        '{ROW_ECHO, '0, 32'd17400,    1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_PROCESS_NOISE, 32'hFFFF_FFFF, 1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_MEASUREMENT_NOISE, 32'hFFFF_FFFF, 1'b0, 25'd0, STATUS_OK},
        '{ROW_ECHO, '0, 32'd5800,     1'b0, 25'd0, STATUS_OK},
        '{ROW_ECHO, '0, 32'd5800,     1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_INITIAL_ERROR, 32'd0, 1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_INITIAL_ESTIMATE, 32'd26214400, 1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_TIMEOUT_US, 32'd1, 1'b0, 25'd0, STATUS_OK},
        '{ROW_ECHO, '0, 32'd1,        1'b0, 25'd0, STATUS_OK},
        '{ROW_ECHO, '0, 32'd2,        1'b1, 25'd0, STATUS_TIMEOUT},
        '{ROW_CFG,  REG_TIMEOUT_US, 32'd65535, 1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_UNUSED, 32'hFFFF_FFFF, 1'b0, 25'd0, STATUS_OK},
        '{ROW_ECHO, '0, 32'd65535,    1'b1, 25'd0, STATUS_RANGE},
        '{ROW_ECHO, '0, 32'd23200,    1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_PROCESS_NOISE, 32'd6554, 1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_MEASUREMENT_NOISE, 32'd6554, 1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_MIN_CM, 32'd2, 1'b0, 25'd0, STATUS_OK},
        '{ROW_CFG,  REG_TIMEOUT_US, 32'd26000, 1'b0, 25'd0, STATUS_OK}
    };

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Gate the echo width, then run one fixed-point Kalman step on the state.
    function automatic range_result_t filter_echo(input logic [PW_W-1:0] pw);
        range_result_t res;
        logic [63:0]   p_pred;
        logic [63:0]   denom;
        logic [63:0]   gain;
        logic [63:0]   meas;
        logic [63:0]   x_next;
        res.distance = '0;
        res.status   = STATUS_OK;
        if (pw == '0 || pw > timeout_limit)
        begin
            res.status = STATUS_TIMEOUT;
            return res;
        end
        if (int'(pw) < int'(min_range_cm) * US_PER_CM
            || int'(pw) > int'(max_range_cm) * US_PER_CM)
        begin
            res.status = STATUS_RANGE;
            return res;
        end
        meas   = ({48'd0, pw} << FRAC_W) / 64'(US_PER_CM);
        p_pred = {32'd0, cov_q16} + {32'd0, noise_q};
        if (p_pred > 64'hFFFF_FFFF)
            p_pred = 64'hFFFF_FFFF;
        denom = p_pred + {32'd0, noise_r};
        gain  = (denom == 0) ? 64'd0 : (p_pred << FRAC_W) / denom;
        if (gain > 64'd65536)
            gain = 64'd65536;
        x_next = {39'd0, est_q16};
        // The correction is truncated toward the old estimate on both sides.
        if (meas >= x_next)
            x_next = x_next + ((gain * (meas - x_next)) >> FRAC_W);
        else
            x_next = x_next - ((gain * (x_next - meas)) >> FRAC_W);
        p_pred  = (p_pred * (64'd65536 - gain)) >> FRAC_W;
        est_q16 = x_next[DIST_W-1:0];
        cov_q16 = p_pred[COV_W-1:0];
        res.distance = est_q16;
        return res;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [31:0] data);
        case (idx)
            REG_PROCESS_NOISE:     noise_q       = data;
            REG_MEASUREMENT_NOISE: noise_r       = data;
            REG_INITIAL_ERROR:     init_cov      = data;
            REG_INITIAL_ESTIMATE:  init_est      = data[DIST_W-1:0];
            REG_TIMEOUT_US:        timeout_limit = data[PW_W-1:0];
            REG_MIN_CM:            min_range_cm  = data[CM_W-1:0];
            REG_MAX_CM:            max_range_cm  = data[CM_W-1:0];
            default:               ;
        endcase
    endfunction

    // Mostly widths inside the accepted window, the rest corners and noise.
    function automatic logic [PW_W-1:0] pick_width();
        int low_edge;
        int high_edge;
        int lo;
        int hi;
        int roll;
        low_edge  = int'(min_range_cm) * US_PER_CM;
        high_edge = int'(max_range_cm) * US_PER_CM;
        roll      = $urandom_range(0, 99);
        if (roll < 70)
        begin
            lo = (low_edge < 1) ? 1 : low_edge;
            hi = (int'(timeout_limit) < high_edge) ? int'(timeout_limit) : high_edge;
            if (lo <= hi)
                return PW_W'($urandom_range(lo, hi));
            return PW_W'($urandom);
        end
        if (roll < 85)
        begin
            case ($urandom_range(0, 5))
                0:       return PW_W'(low_edge - 1);
                1:       return PW_W'(low_edge);
                2:       return PW_W'(high_edge);
                3:       return PW_W'(high_edge + 1);
                4:       return timeout_limit;
                default: return PW_W'(int'(timeout_limit) + 1);
            endcase
        end
        if (roll < 95)
            return PW_W'($urandom);
        return ($urandom_range(0, 1) == 0) ? '0 : '1;
    endfunction

    task automatic send_echo(input logic [PW_W-1:0] pw, input bit use_typed,
                             input range_result_t typed_result);
        range_result_t predicted;
        int            gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = steady_sender ? 0 : $urandom_range(0, 12);
            if (gap != 0)
            begin
                echo_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        echo_ch.valid       <= 1'b1;
        echo_ch.pulse_width <= pw;
        do @(posedge clk); while (!echo_ch.ready);
        predicted = filter_echo(pw);
        pending_ranges.push_back(use_typed ? typed_result : predicted);
        block_busy = 1'b1;
    endtask

    // Hold the sender until every pending result has been seen.
    task automatic drain_results();
        echo_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_ranges.size() != 0);
    endtask

    // The block is idle only once the pipe is empty and a latency has passed.
    task automatic settle_block();
        if (!block_busy)
            return;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        block_busy = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        apply_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_setting(input logic [31:0] q, input logic [31:0] r,
                                input logic [31:0] p0, input logic [31:0] x0,
                                input logic [31:0] tmo, input logic [31:0] lo_cm,
                                input logic [31:0] hi_cm);
        settle_block();
        write_reg(REG_PROCESS_NOISE, q);
        write_reg(REG_MEASUREMENT_NOISE, r);
        write_reg(REG_INITIAL_ERROR, p0);
        write_reg(REG_INITIAL_ESTIMATE, x0);
        write_reg(REG_TIMEOUT_US, tmo);
        write_reg(REG_MIN_CM, lo_cm);
        write_reg(REG_MAX_CM, hi_cm);
    endtask

    // Result sink: steady, coin-flip, or long stalls with short open windows.
    always @(posedge clk)
    begin
        if (sink_hold != 0)
            sink_hold--;
        else
        begin
            case (sink_mode)
                SINK_STEADY: result_ch.ready <= 1'b1;
                SINK_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (result_ch.ready)
                    begin
                        result_ch.ready <= 1'b0;
                        sink_hold = $urandom_range(1, 40);
                    end
                    else
                    begin
                        result_ch.ready <= 1'b1;
                        sink_hold = $urandom_range(1, 20);
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_ranges.size() == 0)
                report_mismatch("result with nothing pending", result_ch.distance, 0);
            else
            begin
                oldest_range = pending_ranges.pop_front();
                if (result_ch.distance !== oldest_range.distance)
                    report_mismatch("distance", result_ch.distance, oldest_range.distance);
                if (result_ch.status !== oldest_range.status)
                    report_mismatch("status", result_ch.status, oldest_range.status);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((echo_ch.valid && echo_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        range_result_t typed;
        logic [31:0]   q;
        logic [31:0]   r;
        logic [31:0]   tmo;
        logic [31:0]   lo_cm;
        logic [31:0]   hi_cm;
        rst_n               = 1'b0;
        echo_ch.valid       = 1'b0;
        echo_ch.pulse_width = '0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // The filter state loads from the initial registers just after reset.
        repeat (3) @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                settle_block();
                write_reg(directed_rows[i].index, directed_rows[i].value);
            end
            else
            begin
                typed.distance = directed_rows[i].distance;
                typed.status   = directed_rows[i].status;
                send_echo(directed_rows[i].value[PW_W-1:0], directed_rows[i].typed, typed);
            end
        end

        typed.distance = '0;
        typed.status   = STATUS_OK;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            q     = $urandom;
            r     = $urandom;
            tmo   = $urandom_range(1, 65535);
            lo_cm = $urandom_range(0, 400);
            hi_cm = $urandom_range(1, 400);
            case (phase)
                0: begin q = 6554; r = 6554; tmo = 26000; lo_cm = 2; hi_cm = 400; end
                1: begin q = 0; r = 32'hFFFF_FFFF; tmo = 26000; lo_cm = 2; hi_cm = 400; end
                2: begin q = 32'hFFFF_FFFF; r = 0; tmo = 65535; lo_cm = 0; hi_cm = 400; end
                3: begin tmo = 65535; lo_cm = 0; hi_cm = 400; end
                4: begin q = q & 32'hFFFF; r = r & 32'hFFFF; end
                5: begin tmo = 65535; hi_cm = $urandom_range(1, 400); lo_cm = hi_cm; end
                6: begin lo_cm = $urandom_range(201, 400); hi_cm = $urandom_range(1, 200); end
                7: begin q = q & 32'hFF; r = r & 32'hFF; tmo = 26000; lo_cm = 2; hi_cm = 400; end
                default: ;
            endcase
            load_setting(q, r, $urandom, $urandom_range(0, 26214400), tmo, lo_cm, hi_cm);
            if (phase == RANDOM_PHASES - 1)
                write_reg(REG_UNUSED, $urandom);
            steady_sender = (phase % 4 == 0);
            sink_mode     = sink_mode_e'(phase % 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2)
                    drain_results();
                send_echo(pick_width(), 1'b0, typed);
            end
        end

        settle_block();
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
